@@ rtl/isort_pkg.sv @@
`timescale 1ns / 1ps
package isort_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int VAL_W     = 32;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic             last;
	} in_t;

	typedef struct packed {
		logic [VAL_W-1:0] sorted_value;
		logic             final_res;
		logic             overflow;
	} out_t;

	// sideband that travels with a buffer read during emission
	typedef struct packed {
		logic valid;
		logic final_res;
		logic overflow;
	} emit_t;

endpackage

@@ rtl/isort_mem.sv @@
`timescale 1ns / 1ps
module isort_mem #(
	parameter int DEPTH = isort_pkg::DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [AW-1:0]                 waddr,
	input  logic [isort_pkg::VAL_W-1:0]   wdata,
	input  logic [AW-1:0]                 raddr,
	output logic [isort_pkg::VAL_W-1:0]   rdata
);

	logic [isort_pkg::VAL_W-1:0] mem_q [DEPTH];
	logic [isort_pkg::VAL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/isort_seq.sv @@
`timescale 1ns / 1ps
module isort_seq #(
	parameter int DEPTH = isort_pkg::DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH),
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  isort_pkg::in_t                item,
	output logic                          busy,
	output logic                          mem_we,
	output logic [AW-1:0]                 mem_waddr,
	output logic [isort_pkg::VAL_W-1:0]   mem_wdata,
	output logic [AW-1:0]                 mem_raddr,
	input  logic [isort_pkg::VAL_W-1:0]   mem_rdata,
	output isort_pkg::emit_t              emit_s1
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_PLACE,
		ST_EMIT
	} state_t;

	state_t                      state_q;
	logic [isort_pkg::VAL_W-1:0] key_q;
	logic                        last_q;
	logic [AW-1:0]               pos_q;
	logic [CW-1:0]               count_q;
	logic                        drop_q;
	logic [AW-1:0]               k_q;

	logic          accept;
	logic          full;
	logic [CW-1:0] cnt_m1;
	logic          gt;
	logic          k_final;

	assign accept  = start && (state_q == ST_IDLE);
	assign full    = (count_q == CW'(DEPTH));
	assign cnt_m1  = count_q - CW'(1);
	assign gt      = (mem_rdata > key_q);
	assign k_final = (CW'(k_q) == cnt_m1);
	assign busy    = (state_q != ST_IDLE);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = key_q;
		mem_raddr = cnt_m1[AW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				// empty set: store at the bottom directly
				if (accept && !full && (count_q == '0)) begin
					mem_we    = 1'b1;
					mem_waddr = '0;
					mem_wdata = item.value;
				end
			end
			ST_SHIFT: begin
				mem_we = 1'b1;
				if (gt) begin
					mem_wdata = mem_rdata;
					mem_raddr = pos_q - AW'(2);
				end
			end
			ST_PLACE: begin
				mem_we    = 1'b1;
				mem_waddr = '0;
			end
			ST_EMIT: begin
				mem_raddr = k_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			key_q   <= '0;
			last_q  <= 1'b0;
			pos_q   <= '0;
			count_q <= '0;
			drop_q  <= 1'b0;
			k_q     <= '0;
			emit_s1 <= '0;
		end else begin
			emit_s1.valid     <= (state_q == ST_EMIT);
			emit_s1.final_res <= (state_q == ST_EMIT) && k_final;
			emit_s1.overflow  <= (state_q == ST_EMIT) && drop_q;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						key_q  <= item.value;
						last_q <= item.last;
						k_q    <= '0;
						if (full) begin
							// drop the transfer, but still flush on last
							drop_q <= 1'b1;
							if (item.last) begin
								state_q <= ST_EMIT;
							end
						end else if (count_q == '0) begin
							count_q <= count_q + CW'(1);
							if (item.last) begin
								state_q <= ST_EMIT;
							end
						end else begin
							pos_q   <= count_q[AW-1:0];
							state_q <= ST_SHIFT;
						end
					end
				end
				ST_SHIFT: begin
					if (gt) begin
						if (pos_q == AW'(1)) begin
							state_q <= ST_PLACE;
						end
						pos_q <= pos_q - AW'(1);
					end else begin
						count_q <= count_q + CW'(1);
						state_q <= last_q ? ST_EMIT : ST_IDLE;
					end
				end
				ST_PLACE: begin
					count_q <= count_q + CW'(1);
					state_q <= last_q ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					k_q <= k_q + AW'(1);
					if (k_final) begin
						count_q <= '0;
						drop_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/insertion_sort_engine.sv @@
`timescale 1ns / 1ps
// Stable ascending sort of one set of unsigned 32-bit values. Present one value per
// transfer (start high while busy is low); the transfer with last set closes the set.
// A value entering an empty or full set is stored or dropped on acceptance; else one
// comparator walks the buffer downwards past each stored entry greater than it, one
// shift per cycle, limited by the single write port of the buffer. After the closing
// transfer the n results leave one per cycle on result_strobe, each read from the
// buffer and then registered at the output; busy stays high while the buffer is read,
// and the last two results leave after busy has fallen. Results cannot be held off,
// so the receiver must take each one in the cycle it appears. Values beyond DEPTH are
// dropped and every result of that set then carries overflow.
module insertion_sort_engine #(
	parameter int DEPTH = isort_pkg::DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  isort_pkg::in_t    item,
	output logic              busy,
	output logic              result_strobe,
	output isort_pkg::out_t   result
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic                        mem_we;
	logic [AW-1:0]               mem_waddr;
	logic [isort_pkg::VAL_W-1:0] mem_wdata;
	logic [AW-1:0]               mem_raddr;
	logic [isort_pkg::VAL_W-1:0] mem_rdata;
	isort_pkg::emit_t            emit_s1;

	logic            strobe_q;
	isort_pkg::out_t result_q;

	isort_seq #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.busy      (busy),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.emit_s1   (emit_s1)
	);

	isort_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output stage: hold the strobe under reset, payload needs none
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= emit_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		result_q.sorted_value <= mem_rdata;
		result_q.final_res    <= emit_s1.final_res;
		result_q.overflow     <= emit_s1.overflow;
	end

	assign result_strobe = strobe_q;
	assign result        = result_q;

	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.last |=> busy)
		else $error("closing transfer did not start a read-out");

	a_final_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.final_res |=> !result_strobe)
		else $error("result directly after final result");

	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !result.final_res |=>
			result_strobe && (result.overflow == $past(result.overflow)))
		else $error("read-out broken or overflow changed within a set");

endmodule
